[src/vclsp_pkg.sv]
// shared types, constants and derived frame timing for the client link and status ports
// no dependencies; used by the parser, the status pipeline and the top level
package vclsp_pkg;

    // frame timing
    localparam int unsigned FRAME_PERIOD    = 33367;
    localparam int unsigned LINES_PER_FRAME = 262;

    localparam int unsigned LINE_DIV      = (LINES_PER_FRAME == 0) ? 1 : LINES_PER_FRAME;
    localparam int unsigned LINE_LEN_RAW  = FRAME_PERIOD / LINE_DIV;
    localparam int unsigned LINE_LEN      = (LINE_LEN_RAW == 0) ? 1 : LINE_LEN_RAW;

    // reciprocal constants: quotient estimate is exact or one low
    localparam int unsigned FRAME_SHIFT = 31 + $clog2(FRAME_PERIOD);
    localparam int unsigned FRAME_QW    = 64 - FRAME_SHIFT;
    localparam logic [63:0] FRAME_RECIP_FULL = (64'd1 << FRAME_SHIFT) / 64'(FRAME_PERIOD);
    localparam logic [31:0] FRAME_RECIP = FRAME_RECIP_FULL[31:0];
    localparam logic [31:0] FRAME_LEN   = 32'(FRAME_PERIOD);
    localparam int unsigned REM_W       = $clog2(2 * FRAME_PERIOD);

    localparam int unsigned LINE_SHIFT = 31 + $clog2(LINE_LEN);
    localparam int unsigned LINE_QW    = 64 - LINE_SHIFT;
    localparam logic [63:0] LINE_RECIP_FULL = (64'd1 << LINE_SHIFT) / 64'(LINE_LEN);
    localparam logic [31:0] LINE_RECIP = LINE_RECIP_FULL[31:0];
    localparam logic [31:0] LINE_LEN_W = 32'(LINE_LEN);

    localparam logic [31:0] BLANK_CYCLES   = 32'd8000;
    localparam logic [7:0]  STATUS_ALL_SET = 8'hFF;
    localparam logic [7:0]  MASK_BLANK     = 8'h3F;
    localparam logic [7:0]  MASK_ODD_LINE  = 8'h7F;

    // item kinds on the input channel
    localparam logic OP_CLIENT_BYTE = 1'b0;
    localparam logic OP_PORT_READ   = 1'b1;

    // message kinds (high nibble of the first byte)
    localparam logic [3:0] MSG_JOY1    = 4'h1;
    localparam logic [3:0] MSG_JOY2    = 4'h2;
    localparam logic [3:0] MSG_KEY     = 4'h3;
    localparam logic [3:0] MSG_VSYNC   = 4'h4;
    localparam logic [3:0] MSG_VERSION = 4'hF;

    localparam logic [3:0]  VERSION_EXT_MIN     = 4'd2;
    localparam logic [15:0] OLD_CLIENT_FEATURES = 16'h000F;
    localparam int unsigned FEAT_VSYNC_BIT      = 3;

    // cpu ports
    localparam logic [7:0] PORT_STATUS    = 8'h0E;
    localparam logic [7:0] PORT_JOY_FIRST = 8'h18;
    localparam logic [7:0] PORT_JOY_LAST  = 8'h1C;
    localparam int unsigned JOY_PORTS     = 5;
    localparam int unsigned JOY_IDX_W     = $clog2(JOY_PORTS);
    localparam logic [7:0] JOY0_RESET     = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_JOY1_A = 3'd1,
        PH_JOY1_B = 3'd2,
        PH_JOY2_A = 3'd3,
        PH_JOY2_B = 3'd4,
        PH_KEY    = 3'd5,
        PH_VER_A  = 3'd6,
        PH_VER_B  = 3'd7
    } parse_phase_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        key_valid;
        logic [7:0]  key_byte;
        logic [15:0] client_features;
        logic        version_known;
        logic [3:0]  client_version;
    } result_t;

    typedef struct packed {
        result_t     res;
        logic        is_status;
        logic        vsync_mode;
        logic [31:0] now;
        logic [31:0] diff;
    } pipe_item_t;

endpackage

[src/video_client_link_and_status_ports.sv]
// Client link and status ports of an emulated video card with a joystick board.
// Input channel s_*: one item is either a byte from the display client
// (s_tuser = 0) or a CPU input-port read (s_tuser = 1), with the cycle count.
// Client bytes run a message parser that fills five joystick bytes, forwards
// key bytes, takes the client version and feature word and stamps vsync.
// Port 0x0E reads frame/line status, ports 0x18 to 0x1C read the joystick bytes,
// any other port reads 0.
// Output channel m_*: exactly one result item per input item, in order.
// Throughput: one item per cycle unless m_tready stalls the output. An accepted
// item reaches m_tvalid through the six registers of the status path: input, frame
// quotient multiply, remainder, remainder correct, line quotient multiply and
// the output register.
// Parser state is updated at the edge that accepts a client byte.
// Reset (rst_n low) clears the pipeline, the parser to idle, joystick port 0
// to 0xFF and the other four to 0, and the version and feature state to 0.
// When m_tready is low the pipeline keeps filling; s_tready falls only once
// all six stages hold items, and rises again as soon as the output is taken.
// depends on vclsp_pkg, vclsp_parser and vclsp_status_pipe
module video_client_link_and_status_ports (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // rx_byte[7:0], port_number[15:8], cycle_now[47:16]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_data[7:0], key_valid[8], key_byte[16:9],
                                   // client_features[32:17], version_known[33],
                                   // client_version[37:34], zero[39:38]
);
    import vclsp_pkg::*;

    logic       accept;
    pipe_item_t item;
    result_t    res;

    assign accept = s_tvalid && s_tready;

    vclsp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .operation   (s_tuser[0]),
        .rx_byte     (s_tdata[7:0]),
        .port_number (s_tdata[15:8]),
        .cycle_now   (s_tdata[47:16]),
        .item        (item)
    );

    vclsp_status_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {2'b00, res.client_version, res.version_known, res.client_features,
                      res.key_byte, res.key_valid, res.read_data};

endmodule

[src/vclsp_parser.sv]
// client message parser, joystick/version/vsync state and the direct part of port reads
// depends on vclsp_pkg
module vclsp_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   operation,
    input  logic [7:0]             rx_byte,
    input  logic [7:0]             port_number,
    input  logic [31:0]            cycle_now,
    output vclsp_pkg::pipe_item_t  item
);
    import vclsp_pkg::*;

    parse_phase_t phase_reg, phase_next;
    logic [7:0]   joy_reg [JOY_PORTS];
    logic [7:0]   joy_next [JOY_PORTS];
    logic [15:0]  feature_reg, feature_next;
    logic         vknown_reg, vknown_next;
    logic [3:0]   version_reg, version_next;
    logic [3:0]   pend_ver_reg, pend_ver_next;
    logic [7:0]   pend_low_reg, pend_low_next;
    logic [31:0]  vsync_reg, vsync_next;

    logic                 is_rx;
    logic                 key_hit;
    logic                 joy_hit;
    logic [JOY_IDX_W-1:0] joy_idx;

    assign is_rx = !operation;

    always_comb
    begin
        phase_next    = phase_reg;
        joy_next      = joy_reg;
        feature_next  = feature_reg;
        vknown_next   = vknown_reg;
        version_next  = version_reg;
        pend_ver_next = pend_ver_reg;
        pend_low_next = pend_low_reg;
        vsync_next    = vsync_reg;
        if (is_rx)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    unique case (rx_byte[7:4])
                        MSG_JOY1:
                        begin
                            joy_next[0] = {joy_reg[0][7:4], rx_byte[3:0]};
                            phase_next  = PH_JOY1_A;
                        end
                        MSG_JOY2:
                        begin
                            joy_next[0] = {rx_byte[3:0], joy_reg[0][3:0]};
                            phase_next  = PH_JOY2_A;
                        end
                        MSG_KEY:
                        begin
                            phase_next = PH_KEY;
                        end
                        MSG_VSYNC:
                        begin
                            vsync_next = cycle_now;
                        end
                        MSG_VERSION:
                        begin
                            // old clients report no feature word
                            if (rx_byte[3:0] < VERSION_EXT_MIN)
                            begin
                                feature_next = OLD_CLIENT_FEATURES;
                                version_next = rx_byte[3:0];
                                vknown_next  = 1'b1;
                            end
                            else
                            begin
                                pend_ver_next = rx_byte[3:0];
                                phase_next    = PH_VER_A;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                PH_JOY1_A:
                begin
                    joy_next[1] = rx_byte;
                    phase_next  = PH_JOY1_B;
                end
                PH_JOY1_B:
                begin
                    joy_next[2] = rx_byte;
                    phase_next  = PH_IDLE;
                end
                PH_JOY2_A:
                begin
                    joy_next[3] = rx_byte;
                    phase_next  = PH_JOY2_B;
                end
                PH_JOY2_B:
                begin
                    joy_next[4] = rx_byte;
                    phase_next  = PH_IDLE;
                end
                PH_KEY:
                begin
                    phase_next = PH_IDLE;
                end
                PH_VER_A:
                begin
                    pend_low_next = rx_byte;
                    phase_next    = PH_VER_B;
                end
                PH_VER_B:
                begin
                    feature_next = {rx_byte, pend_low_reg};
                    version_next = pend_ver_reg;
                    vknown_next  = 1'b1;
                    phase_next   = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            joy_reg[0]   <= JOY0_RESET;
            for (int i = 1; i < JOY_PORTS; i++)
            begin
                joy_reg[i] <= 8'h00;
            end
            feature_reg  <= 16'h0000;
            vknown_reg   <= 1'b0;
            version_reg  <= 4'h0;
            pend_ver_reg <= 4'h0;
            pend_low_reg <= 8'h00;
            vsync_reg    <= 32'h0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            joy_reg      <= joy_next;
            feature_reg  <= feature_next;
            vknown_reg   <= vknown_next;
            version_reg  <= version_next;
            pend_ver_reg <= pend_ver_next;
            pend_low_reg <= pend_low_next;
            vsync_reg    <= vsync_next;
        end
    end

    // item as it enters the status pipeline, with state as left by this item
    assign key_hit = is_rx && (phase_reg == PH_KEY);
    assign joy_hit = operation && (port_number >= PORT_JOY_FIRST)
                     && (port_number <= PORT_JOY_LAST);
    assign joy_idx = JOY_IDX_W'(port_number - PORT_JOY_FIRST);

    always_comb
    begin
        item.res.read_data       = joy_hit ? joy_reg[joy_idx] : 8'h00;
        item.res.key_valid       = key_hit;
        item.res.key_byte        = key_hit ? rx_byte : 8'h00;
        item.res.client_features = feature_next;
        item.res.version_known   = vknown_next;
        item.res.client_version  = version_next;
        item.is_status           = operation && (port_number == PORT_STATUS);
        item.vsync_mode          = feature_reg[FEAT_VSYNC_BIT];
        item.now                 = cycle_now;
        item.diff                = cycle_now - vsync_reg;
    end

`ifndef SYNTHESIS
    a_read_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && operation |=> $stable(phase_reg))
        else $error("port read changed the parse phase");

    a_key_from_key_phase: assert property (@(posedge clk) disable iff (!rst_n)
        item.res.key_valid |-> !operation && phase_reg == PH_KEY)
        else $error("key forwarded outside the key phase");
`endif

endmodule

[src/vclsp_status_pipe.sv]
// pipeline that works out the frame/line status byte and carries every item to the output register
// depends on vclsp_pkg
module vclsp_status_pipe (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  vclsp_pkg::pipe_item_t  in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output vclsp_pkg::result_t     out_res
);
    import vclsp_pkg::*;

    // stage valids, each stage moves when empty or when the next one moves
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic go1, go2, go3, go4, go5, go6;

    pipe_item_t i1_reg, i2_reg, i3_reg;
    result_t    res4_reg, res5_reg, res6_reg;
    logic       st4_reg, st5_reg;

    logic [63:0]         prod1;
    logic [FRAME_QW-1:0] q1_next, q1_reg;
    logic [31:0]         rem_wide;
    logic [REM_W-1:0]    rem_next, rem_reg;
    logic [REM_W-1:0]    rem_fixed;
    logic [31:0]         c_next, c4_reg, c5_reg;
    logic [63:0]         prod2;
    logic [LINE_QW-1:0]  q2_next, q2_reg;
    logic [31:0]         r2;
    logic                odd_line;
    logic [7:0]          status;
    result_t             res_next;

    assign go6 = !v6_reg || out_ready;
    assign go5 = !v5_reg || go6;
    assign go4 = !v4_reg || go5;
    assign go3 = !v3_reg || go4;
    assign go2 = !v2_reg || go3;
    assign go1 = !v1_reg || go2;
    assign in_ready = go1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (go1)
            begin
                v1_reg <= in_valid;
            end
            if (go2)
            begin
                v2_reg <= v1_reg;
            end
            if (go3)
            begin
                v3_reg <= v2_reg;
            end
            if (go4)
            begin
                v4_reg <= v3_reg;
            end
            if (go5)
            begin
                v5_reg <= v4_reg;
            end
            if (go6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    // frame quotient estimate, exact or one low
    assign prod1   = {32'h0, i1_reg.now} * {32'h0, FRAME_RECIP};
    assign q1_next = prod1[63:FRAME_SHIFT];

    // remainder before correction stays below twice the frame length
    assign rem_wide = i2_reg.now - 32'(q1_reg * FRAME_LEN);
    assign rem_next = rem_wide[REM_W-1:0];

    assign rem_fixed = (rem_reg >= REM_W'(FRAME_PERIOD))
                       ? rem_reg - REM_W'(FRAME_PERIOD) : rem_reg;
    assign c_next    = i3_reg.vsync_mode ? i3_reg.diff : 32'(rem_fixed);

    assign prod2   = {32'h0, c4_reg} * {32'h0, LINE_RECIP};
    assign q2_next = prod2[63:LINE_SHIFT];

    // line parity, with the one-low estimate corrected
    assign r2       = c5_reg - 32'(q2_reg * LINE_LEN_W);
    assign odd_line = q2_reg[0] ^ (r2 >= LINE_LEN_W);

    always_comb
    begin
        status = STATUS_ALL_SET;
        if (c5_reg < BLANK_CYCLES)
        begin
            status = status & MASK_BLANK;
        end
        if (odd_line)
        begin
            status = status & MASK_ODD_LINE;
        end
        res_next = res5_reg;
        if (st5_reg)
        begin
            res_next.read_data = status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go1)
        begin
            i1_reg <= in_item;
        end
        if (go2)
        begin
            i2_reg <= i1_reg;
            q1_reg <= q1_next;
        end
        if (go3)
        begin
            i3_reg  <= i2_reg;
            rem_reg <= rem_next;
        end
        if (go4)
        begin
            res4_reg <= i3_reg.res;
            st4_reg  <= i3_reg.is_status;
            c4_reg   <= c_next;
        end
        if (go5)
        begin
            res5_reg <= res4_reg;
            st5_reg  <= st4_reg;
            c5_reg   <= c4_reg;
            q2_reg   <= q2_next;
        end
        if (go6)
        begin
            res6_reg <= res_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_res   = res6_reg;

`ifndef SYNTHESIS
    a_key_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_res.key_valid |-> out_res.read_data == 8'h00)
        else $error("key item carries port data");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !go2 |=> v1_reg && $stable(i1_reg))
        else $error("stalled item lost in first stage");
`endif

endmodule
